>>> hdl/cbc_pkg.sv
// Shared constants and types for the cartridge bank controller.
package cbc_pkg;

	localparam int unsigned ROM_BANK_COUNT_DEF = 128;
	localparam int unsigned RAM_BYTES_DEF      = 32768;

	localparam int unsigned ROM_BANK_BYTES = 16384;
	localparam int unsigned RAM_BANK_BYTES = 8192;

	localparam logic [15:0] ADDR_ROM_SWITCH = 16'h4000;
	localparam logic [15:0] ADDR_ROM_END    = 16'h8000;
	localparam logic [15:0] ADDR_RAM_START  = 16'hA000;
	localparam logic [15:0] ADDR_RAM_END    = 16'hC000;
	localparam logic [15:0] ADDR_ROM_BANK   = 16'h2000;
	localparam logic [15:0] ADDR_MODE_REG   = 16'h6000;

	localparam logic [6:0] ROM_BANK_MASK   = 7'h7F;
	localparam logic [7:0] RAM_ENABLE_CODE = 8'h0A;
	localparam logic [7:0] RAM_DISABLE_CODE = 8'h00;
	localparam logic [7:0] RAM_BANK_MAX    = 8'h03;
	localparam logic [7:0] UNMAPPED_BYTE   = 8'hFF;

	typedef enum logic [2:0] {
		MODE_READ_ROM = 3'd0,
		MODE_READ_RAM = 3'd1,
		MODE_BUS_WRITE = 3'd2,
		MODE_LOAD_ROM = 3'd3,
		MODE_LOAD_RAM = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		SEL_ZERO,
		SEL_FF,
		SEL_ROM,
		SEL_RAM
	} sel_t;

endpackage

>>> hdl/cbc_ram.sv
// Generic single-port RAM with registered read data.
module cbc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   addr,
	input  logic [WIDTH-1:0]           wdata,
	output logic [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/cartridge_bank_controller.sv
// Banked cartridge memory mapper: ROM and RAM stores with bank select registers.
//
// Each request makes at most one access to the ROM or RAM memory, issued in the cycle it
// is accepted; a new request may be accepted every cycle while s_axis_tready is high.
// The response passes through the memory read register and then the output register
// and holds while m_axis_tready is low, which stalls the input once both stages are
// full. Bank register writes take effect for the very next request. Stores are not
// initialized; reads of never-written bytes return arbitrary data. Requests carry mode
// in s_axis_tuser; responses carry the RAM enable flag, as it stands after the request,
// in m_axis_tuser.
module cartridge_bank_controller #(
	parameter int unsigned ROM_BANK_COUNT = cbc_pkg::ROM_BANK_COUNT_DEF,
	parameter int unsigned RAM_BYTES      = cbc_pkg::RAM_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // bus_address[15:0], load_address[36:16], data_in[44:37]
	input  logic [2:0]  s_axis_tuser,  // mode[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // read_data[7:0]
	output logic        m_axis_tuser   // ram_enabled[0]
);

	import cbc_pkg::*;

	localparam int unsigned RomBankW = $clog2(ROM_BANK_COUNT);
	localparam int unsigned RomAw    = RomBankW + $clog2(ROM_BANK_BYTES);
	localparam int unsigned RomBytes = ROM_BANK_COUNT * ROM_BANK_BYTES;
	localparam int unsigned RamAw    = $clog2(RAM_BYTES);

	mode_t       mode;
	logic [15:0] bus_address;
	logic [20:0] load_address;
	logic [7:0]  data_in;
	logic        accept;
	logic        advance;

	logic [RomBankW-1:0] rom_bank_q;
	logic [1:0]          ram_bank_q;
	logic                ram_enable_q;

	logic                s1_valid_q;
	sel_t                sel_s1;
	logic                ram_enabled_s1;
	logic                out_valid_q;
	logic [7:0]          out_data_q;
	logic                out_enabled_q;

	logic [6:0]          bank_mod;
	logic [14:0]         ram_off;
	logic [RomAw-1:0]    rom_addr;
	logic [RamAw-1:0]    ram_addr;
	logic                rom_we;
	logic                rom_re;
	logic                ram_we;
	logic                ram_re;
	logic [7:0]          rom_rdata;
	logic [7:0]          ram_rdata;
	logic                ram_enable_next;
	logic                rom_bank_we;
	logic                ram_bank_we;
	sel_t                sel_next;
	logic                in_ram_window;

	assign mode         = mode_t'(s_axis_tuser);
	assign bus_address  = s_axis_tdata[15:0];
	assign load_address = s_axis_tdata[36:16];
	assign data_in      = s_axis_tdata[44:37];

	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !s1_valid_q || advance;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign in_ram_window = (bus_address >= ADDR_RAM_START) && (bus_address < ADDR_RAM_END);

	always_comb begin
		logic [6:0] b;
		b = data_in[6:0] & ROM_BANK_MASK;
		if (b == 7'd0) begin
			b = 7'd1;
		end
		for (int k = 6; k >= 0; k--) begin
			if (int'(b) >= int'(ROM_BANK_COUNT << k)) begin
				b = b - 7'(ROM_BANK_COUNT << k);
			end
		end
		bank_mod = b;
	end

	always_comb begin
		logic [14:0] v;
		v = {ram_bank_q, 13'd0} + {2'd0, bus_address[12:0]};
		if (int'(v) >= int'(2 * RAM_BYTES)) begin
			v = v - 15'(2 * RAM_BYTES);
		end
		if (int'(v) >= int'(RAM_BYTES)) begin
			v = v - 15'(RAM_BYTES);
		end
		ram_off = v;
	end

	always_comb begin
		rom_we          = 1'b0;
		rom_re          = 1'b0;
		ram_we          = 1'b0;
		ram_re          = 1'b0;
		rom_addr        = {rom_bank_q, bus_address[13:0]};
		ram_addr        = ram_off[RamAw-1:0];
		ram_enable_next = ram_enable_q;
		rom_bank_we     = 1'b0;
		ram_bank_we     = 1'b0;
		sel_next        = SEL_ZERO;
		case (mode)
			MODE_READ_ROM: begin
				if (bus_address < ADDR_ROM_SWITCH) begin
					rom_addr = {{RomBankW{1'b0}}, bus_address[13:0]};
					rom_re   = accept;
					sel_next = SEL_ROM;
				end else if (bus_address < ADDR_ROM_END) begin
					rom_re   = accept;
					sel_next = SEL_ROM;
				end else begin
					sel_next = SEL_FF;
				end
			end
			MODE_READ_RAM: begin
				if (in_ram_window) begin
					ram_re   = accept;
					sel_next = SEL_RAM;
				end else begin
					sel_next = SEL_FF;
				end
			end
			MODE_BUS_WRITE: begin
				if (bus_address < ADDR_ROM_BANK) begin
					if (data_in == RAM_DISABLE_CODE) begin
						ram_enable_next = 1'b0;
					end else if (data_in == RAM_ENABLE_CODE) begin
						ram_enable_next = 1'b1;
					end
				end else if (bus_address < ADDR_ROM_SWITCH) begin
					rom_bank_we = accept;
				end else if (bus_address < ADDR_MODE_REG) begin
					ram_bank_we = accept && (data_in <= RAM_BANK_MAX);
				end else if (in_ram_window) begin
					ram_we = accept;
				end
			end
			MODE_LOAD_ROM: begin
				rom_addr = load_address[RomAw-1:0];
				rom_we   = accept && (int'(load_address) < int'(RomBytes));
			end
			MODE_LOAD_RAM: begin
				ram_addr = load_address[RamAw-1:0];
				ram_we   = accept && (int'(load_address) < int'(RAM_BYTES));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_q   <= RomBankW'(1);
			ram_bank_q   <= 2'd0;
			ram_enable_q <= 1'b0;
			s1_valid_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				ram_enable_q <= ram_enable_next;
			end
			if (rom_bank_we) begin
				rom_bank_q <= bank_mod[RomBankW-1:0];
			end
			if (ram_bank_we) begin
				ram_bank_q <= data_in[1:0];
			end
			if (s_axis_tready) begin
				s1_valid_q <= accept;
			end
			if (advance) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sel_s1         <= sel_next;
			ram_enabled_s1 <= ram_enable_next;
		end
		if (advance && s1_valid_q) begin
			out_enabled_q <= ram_enabled_s1;
			case (sel_s1)
				SEL_ROM: out_data_q <= rom_rdata;
				SEL_RAM: out_data_q <= ram_rdata;
				SEL_FF:  out_data_q <= UNMAPPED_BYTE;
				default: out_data_q <= 8'd0;
			endcase
		end
	end

	cbc_ram #(
		.WIDTH(8),
		.DEPTH(RomBytes)
	) u_rom (
		.clk(clk),
		.we(rom_we),
		.re(rom_re),
		.addr(rom_addr),
		.wdata(data_in),
		.rdata(rom_rdata)
	);

	cbc_ram #(
		.WIDTH(8),
		.DEPTH(RAM_BYTES)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.re(ram_re),
		.addr(ram_addr),
		.wdata(data_in),
		.rdata(ram_rdata)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_enabled_q;

endmodule
